// File: src/fcca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fcca_pkg;

    localparam int NUM_CLUSTERS_DEF = 512;

    localparam logic [15:0] END_MIN    = 16'hFFF8;
    localparam logic [15:0] END_NEW    = 16'hFFFF;
    localparam logic [15:0] FIRST_DATA = 16'd2;
    localparam logic [9:0]  TOTAL_MAX  = 10'd1023;

    localparam logic [2:0] ACT_READ  = 3'd0;
    localparam logic [2:0] ACT_ALLOC = 3'd1;
    localparam logic [2:0] ACT_FREE  = 3'd2;
    localparam logic [2:0] ACT_SEEK  = 3'd3;
    localparam logic [2:0] ACT_COUNT = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FREE  = 2'd1;
    localparam logic [1:0] ST_BROKEN   = 2'd2;

    // datapath operations, one per cycle
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_RD_START,
        OP_SET_FFFF,
        OP_RES_RDATA,
        OP_RES_START,
        OP_APP_INIT,
        OP_APP_BAD,
        OP_APP_GO,
        OP_NEW_INIT,
        OP_FREE_INIT,
        OP_SEEK_INIT,
        OP_CNT_INIT,
        OP_RD_CUR,
        OP_WALK_STEP,
        OP_RD_SCAN,
        OP_SCAN_NEXT,
        OP_LINK,
        OP_MARK,
        OP_FAIL_NEW,
        OP_FAIL,
        OP_FREE_WR,
        OP_SEEK_DONE,
        OP_SEEK_BAD,
        OP_SEEK_STEP,
        OP_CNT_CHK,
        OP_OUT
    } op_t;

    typedef struct packed {
        logic [2:0] act;
        logic       start_zero;
        logic       start_in;
        logic       start_app_ok;
        logic       count_zero;
        logic       nx_end;
        logic       walk_bad;
        logic       rd_zero;
        logic       scan_end;
        logic       have;
        logic       rem_one;
        logic       rem_zero;
        logic       cur_in;
        logic       free_go;
        logic       seek_bad;
        logic       clr_done;
    } dp_stat_t;

endpackage
`default_nettype wire

// File: src/fat16_cluster_chain_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// FAT16 allocation table engine holding one 16-bit entry per cluster in a single-port
// table memory. After reset the block sweeps the table, one entry a cycle,
// to entry 0 = 0xFFF8, entry 1 = 0xFFFF, rest free;
// in_ready stays low until the sweep ends. One request is worked at a time.
// Every table read is registered (address, then registered data). A read
// looks up one entry, a count-free reads every entry from cluster 2 up, a
// seek or free reads one entry per hop, and an allocate reads one entry
// per cluster scanned and marks each cluster it links, plus one read per
// hop of the walk when appending. The free-cluster scan moves forward only
// within a request, so one allocate scans the table at most once. A result
// word waits in an output register while the next request is taken.
module fat16_cluster_chain_allocator #(
    parameter int NUM_CLUSTERS = fcca_pkg::NUM_CLUSTERS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  action,
    input  wire logic [15:0] head_cluster,
    input  wire logic [9:0]  cluster_count,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [15:0] result_cluster,
    output logic      [9:0]  free_total,
    output logic      [1:0]  status
);

    // command and status between sequencer and datapath
    fcca_pkg::op_t      op;
    fcca_pkg::dp_stat_t stat;

    fcca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .op        (op)
    );

    fcca_dp #(
        .NUM_CLUSTERS (NUM_CLUSTERS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .op             (op),
        .action         (action),
        .head_cluster   (head_cluster),
        .cluster_count  (cluster_count),
        .stat           (stat),
        .result_cluster (result_cluster),
        .free_total     (free_total),
        .status         (status)
    );

    // status code 3 is never produced
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status != 2'd3))
        else $error("illegal status code");

    // only count-free reports a total, and it never fails
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != fcca_pkg::ST_OK) |-> (free_total == 10'd0))
        else $error("free total on failed request");

    // table sweep keeps input closed right after reset
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !in_ready)
        else $error("input open during table sweep");

endmodule
`default_nettype wire

// File: src/fcca_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module fcca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

// File: src/fcca_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module fcca_dp #(
    parameter int NUM_CLUSTERS = fcca_pkg::NUM_CLUSTERS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire fcca_pkg::op_t     op,
    input  wire logic [2:0]        action,
    input  wire logic [15:0]       head_cluster,
    input  wire logic [9:0]        cluster_count,
    output fcca_pkg::dp_stat_t     stat,
    output logic      [15:0]       result_cluster,
    output logic      [9:0]        free_total,
    output logic      [1:0]        status
);

    localparam int AW = $clog2(NUM_CLUSTERS);
    localparam int SW = $clog2(NUM_CLUSTERS + 1);
    localparam int CW = $clog2(NUM_CLUSTERS + 2);
    localparam logic [16:0] NC   = 17'(NUM_CLUSTERS);
    localparam logic [SW-1:0] NCS = SW'(NUM_CLUSTERS);
    localparam logic [CW:0] NCC  = (CW + 1)'(NUM_CLUSTERS);
    localparam logic [CW-1:0] CLR_LAST = CW'(NUM_CLUSTERS - 1);

    logic [2:0]    act_reg;
    logic [15:0]   start_reg;
    logic [9:0]    count_reg;
    logic [15:0]   cur_reg;
    logic [15:0]   first_reg;
    logic [SW-1:0] scan_reg;
    logic [9:0]    rem_reg;
    logic [CW-1:0] cnt_reg;
    logic          have_reg;
    logic [15:0]   res_reg;
    logic [1:0]    st_reg;
    logic [9:0]    tot_reg;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [15:0]   ram_wdata;
    logic [15:0]   rdata;
    logic [CW:0]   cnt_inc;

    fcca_ram #(
        .WIDTH (16),
        .DEPTH (NUM_CLUSTERS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (rdata)
    );

    assign cnt_inc = {1'b0, cnt_reg} + (CW + 1)'(1);

    // table port: one access per cycle
    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = scan_reg[AW-1:0];
        ram_wdata = 16'h0000;
        unique case (op)
            fcca_pkg::OP_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = cnt_reg[AW-1:0];
                ram_wdata = (cnt_reg == '0) ? fcca_pkg::END_MIN :
                            (cnt_reg == CW'(1)) ? fcca_pkg::END_NEW : 16'h0000;
            end
            fcca_pkg::OP_RD_START: ram_addr = start_reg[AW-1:0];
            fcca_pkg::OP_RD_CUR:   ram_addr = cur_reg[AW-1:0];
            fcca_pkg::OP_LINK:
            begin
                ram_we    = have_reg;
                ram_addr  = cur_reg[AW-1:0];
                ram_wdata = 16'(scan_reg);
            end
            fcca_pkg::OP_FREE_WR:
            begin
                ram_we    = 1'b1;
                ram_addr  = cur_reg[AW-1:0];
            end
            fcca_pkg::OP_MARK:
            begin
                ram_we    = 1'b1;
                ram_wdata = fcca_pkg::END_NEW;
            end
            default: ram_addr = scan_reg[AW-1:0];
        endcase
    end

    always_comb
    begin
        stat.act          = act_reg;
        stat.start_zero   = (start_reg == 16'h0000);
        stat.start_in     = ({1'b0, start_reg} < NC);
        stat.start_app_ok = (start_reg >= fcca_pkg::FIRST_DATA) && ({1'b0, start_reg} < NC);
        stat.count_zero   = (count_reg == 10'd0);
        stat.nx_end       = (rdata >= fcca_pkg::END_MIN);
        stat.walk_bad     = (rdata < fcca_pkg::FIRST_DATA) || ({1'b0, rdata} >= NC) ||
                            (cnt_inc >= NCC);
        stat.rd_zero      = (rdata == 16'h0000);
        stat.scan_end     = (scan_reg >= NCS);
        stat.have         = have_reg;
        stat.rem_one      = (rem_reg == 10'd1);
        stat.rem_zero     = (rem_reg == 10'd0);
        stat.cur_in       = ({1'b0, cur_reg} < NC);
        stat.free_go      = (cur_reg >= fcca_pkg::FIRST_DATA) && (cur_reg < fcca_pkg::END_MIN) &&
                            ({1'b0, cnt_reg} <= NCC);
        stat.seek_bad     = (rdata < fcca_pkg::FIRST_DATA) || (rdata >= fcca_pkg::END_MIN) ||
                            ({1'b0, rdata} >= NC);
        stat.clr_done     = (cnt_reg == CLR_LAST);
    end

    // counter and flag carry reset, the rest is payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            have_reg <= 1'b0;
        end
        else
        begin
            unique case (op)
                fcca_pkg::OP_CLEAR:     cnt_reg <= cnt_inc[CW-1:0];
                fcca_pkg::OP_LOAD:      cnt_reg <= '0;
                fcca_pkg::OP_WALK_STEP: cnt_reg <= cnt_inc[CW-1:0];
                fcca_pkg::OP_FREE_WR:   cnt_reg <= cnt_inc[CW-1:0];
                fcca_pkg::OP_FAIL_NEW:  cnt_reg <= '0;
                fcca_pkg::OP_NEW_INIT:  have_reg <= 1'b0;
                fcca_pkg::OP_APP_GO:    have_reg <= 1'b1;
                fcca_pkg::OP_MARK:      have_reg <= 1'b1;
                default:                cnt_reg <= cnt_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (op)
            fcca_pkg::OP_LOAD:
            begin
                act_reg   <= action;
                start_reg <= head_cluster;
                count_reg <= cluster_count;
                res_reg   <= 16'h0000;
                st_reg    <= fcca_pkg::ST_OK;
                tot_reg   <= 10'd0;
            end
            fcca_pkg::OP_SET_FFFF:  res_reg <= fcca_pkg::END_NEW;
            fcca_pkg::OP_RES_RDATA: res_reg <= rdata;
            fcca_pkg::OP_RES_START: res_reg <= start_reg;
            fcca_pkg::OP_APP_INIT:
            begin
                res_reg <= start_reg;
                cur_reg <= start_reg;
            end
            fcca_pkg::OP_APP_BAD:
            begin
                res_reg <= start_reg;
                st_reg  <= fcca_pkg::ST_BROKEN;
            end
            fcca_pkg::OP_APP_GO:
            begin
                scan_reg <= SW'(fcca_pkg::FIRST_DATA);
                rem_reg  <= count_reg;
            end
            fcca_pkg::OP_NEW_INIT:
            begin
                scan_reg <= SW'(fcca_pkg::FIRST_DATA);
                rem_reg  <= count_reg;
            end
            fcca_pkg::OP_FREE_INIT:
            begin
                res_reg <= start_reg;
                cur_reg <= start_reg;
            end
            fcca_pkg::OP_SEEK_INIT:
            begin
                cur_reg <= start_reg;
                rem_reg <= count_reg;
            end
            fcca_pkg::OP_CNT_INIT:  scan_reg <= SW'(fcca_pkg::FIRST_DATA);
            fcca_pkg::OP_WALK_STEP: cur_reg <= rdata;
            fcca_pkg::OP_SCAN_NEXT: scan_reg <= scan_reg + SW'(1);
            fcca_pkg::OP_MARK:
            begin
                cur_reg  <= 16'(scan_reg);
                if (!have_reg)
                begin
                    first_reg <= 16'(scan_reg);
                    res_reg   <= 16'(scan_reg);
                end
                rem_reg  <= rem_reg - 10'd1;
                scan_reg <= scan_reg + SW'(1);
            end
            fcca_pkg::OP_FAIL_NEW:
            begin
                res_reg <= 16'h0000;
                st_reg  <= fcca_pkg::ST_NO_FREE;
                cur_reg <= first_reg;
            end
            fcca_pkg::OP_FAIL:      st_reg <= fcca_pkg::ST_NO_FREE;
            fcca_pkg::OP_FREE_WR:   cur_reg <= rdata;
            fcca_pkg::OP_SEEK_DONE: res_reg <= cur_reg;
            fcca_pkg::OP_SEEK_BAD:
            begin
                res_reg <= cur_reg;
                st_reg  <= fcca_pkg::ST_BROKEN;
            end
            fcca_pkg::OP_SEEK_STEP:
            begin
                cur_reg <= rdata;
                rem_reg <= rem_reg - 10'd1;
            end
            fcca_pkg::OP_CNT_CHK:
            begin
                if (rdata == 16'h0000 && tot_reg < fcca_pkg::TOTAL_MAX)
                begin
                    tot_reg <= tot_reg + 10'd1;
                end
                scan_reg <= scan_reg + SW'(1);
            end
            fcca_pkg::OP_OUT:
            begin
                result_cluster <= res_reg;
                free_total     <= tot_reg;
                status         <= st_reg;
            end
            default: res_reg <= res_reg;
        endcase
    end

endmodule
`default_nettype wire

// File: src/fcca_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module fcca_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    input  wire fcca_pkg::dp_stat_t stat,
    output fcca_pkg::op_t           op
);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DISPATCH, S_RD_WAIT,
        S_WALK_RD, S_WALK_CHK, S_SCAN_RD, S_SCAN_CHK, S_MARK,
        S_FREE_CHK, S_FREE_WR, S_SEEK_CHK, S_SEEK_NX,
        S_CNT_RD, S_CNT_CHK, S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        op             = fcca_pkg::OP_NONE;
        out_valid_next = out_valid_reg & ~out_ready;
        unique case (state_reg)
            S_CLEAR:
            begin
                op = fcca_pkg::OP_CLEAR;
                if (stat.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = fcca_pkg::OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_FINISH;
                unique case (stat.act)
                    fcca_pkg::ACT_READ:
                    begin
                        if (stat.start_in)
                        begin
                            op         = fcca_pkg::OP_RD_START;
                            state_next = S_RD_WAIT;
                        end
                        else
                        begin
                            op = fcca_pkg::OP_SET_FFFF;
                        end
                    end
                    fcca_pkg::ACT_ALLOC:
                    begin
                        priority if (stat.count_zero)
                        begin
                            op = stat.start_zero ? fcca_pkg::OP_NONE : fcca_pkg::OP_RES_START;
                        end
                        else if (stat.start_zero)
                        begin
                            op         = fcca_pkg::OP_NEW_INIT;
                            state_next = S_SCAN_RD;
                        end
                        else if (!stat.start_app_ok)
                        begin
                            op = fcca_pkg::OP_APP_BAD;
                        end
                        else
                        begin
                            op         = fcca_pkg::OP_APP_INIT;
                            state_next = S_WALK_RD;
                        end
                    end
                    fcca_pkg::ACT_FREE:
                    begin
                        op         = fcca_pkg::OP_FREE_INIT;
                        state_next = S_FREE_CHK;
                    end
                    fcca_pkg::ACT_SEEK:
                    begin
                        op         = fcca_pkg::OP_SEEK_INIT;
                        state_next = S_SEEK_CHK;
                    end
                    fcca_pkg::ACT_COUNT:
                    begin
                        op         = fcca_pkg::OP_CNT_INIT;
                        state_next = S_CNT_RD;
                    end
                    default: op = fcca_pkg::OP_NONE;
                endcase
            end
            S_RD_WAIT:
            begin
                op         = fcca_pkg::OP_RES_RDATA;
                state_next = S_FINISH;
            end
            S_WALK_RD:
            begin
                op         = fcca_pkg::OP_RD_CUR;
                state_next = S_WALK_CHK;
            end
            S_WALK_CHK:
            begin
                priority if (stat.nx_end)
                begin
                    op         = fcca_pkg::OP_APP_GO;
                    state_next = S_SCAN_RD;
                end
                else if (stat.walk_bad)
                begin
                    op         = fcca_pkg::OP_APP_BAD;
                    state_next = S_FINISH;
                end
                else
                begin
                    op         = fcca_pkg::OP_WALK_STEP;
                    state_next = S_WALK_RD;
                end
            end
            S_SCAN_RD:
            begin
                priority if (!stat.scan_end)
                begin
                    op         = fcca_pkg::OP_RD_SCAN;
                    state_next = S_SCAN_CHK;
                end
                else if (stat.start_zero)
                begin
                    op         = fcca_pkg::OP_FAIL_NEW;
                    state_next = stat.have ? S_FREE_CHK : S_FINISH;
                end
                else
                begin
                    op         = fcca_pkg::OP_FAIL;
                    state_next = S_FINISH;
                end
            end
            S_SCAN_CHK:
            begin
                if (stat.rd_zero)
                begin
                    op         = fcca_pkg::OP_LINK;
                    state_next = S_MARK;
                end
                else
                begin
                    op         = fcca_pkg::OP_SCAN_NEXT;
                    state_next = S_SCAN_RD;
                end
            end
            S_MARK:
            begin
                op         = fcca_pkg::OP_MARK;
                state_next = stat.rem_one ? S_FINISH : S_SCAN_RD;
            end
            S_FREE_CHK:
            begin
                if (stat.free_go && stat.cur_in)
                begin
                    op         = fcca_pkg::OP_RD_CUR;
                    state_next = S_FREE_WR;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FREE_WR:
            begin
                op         = fcca_pkg::OP_FREE_WR;
                state_next = S_FREE_CHK;
            end
            S_SEEK_CHK:
            begin
                priority if (stat.rem_zero)
                begin
                    op         = fcca_pkg::OP_SEEK_DONE;
                    state_next = S_FINISH;
                end
                else if (!stat.cur_in)
                begin
                    op         = fcca_pkg::OP_SEEK_BAD;
                    state_next = S_FINISH;
                end
                else
                begin
                    op         = fcca_pkg::OP_RD_CUR;
                    state_next = S_SEEK_NX;
                end
            end
            S_SEEK_NX:
            begin
                if (stat.seek_bad)
                begin
                    op         = fcca_pkg::OP_SEEK_BAD;
                    state_next = S_FINISH;
                end
                else
                begin
                    op         = fcca_pkg::OP_SEEK_STEP;
                    state_next = S_SEEK_CHK;
                end
            end
            S_CNT_RD:
            begin
                if (stat.scan_end)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    op         = fcca_pkg::OP_RD_SCAN;
                    state_next = S_CNT_CHK;
                end
            end
            S_CNT_CHK:
            begin
                op         = fcca_pkg::OP_CNT_CHK;
                state_next = S_CNT_RD;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    op             = fcca_pkg::OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire
